@@ src/fqts_pkg.sv @@
// Package for the feedback queue task scheduler: sizes, codes and beat types.
// Used by fqts_emit and the scheduler top level; no dependencies of its own.
package fqts_pkg;

  localparam int TASKS      = 16;
  localparam int LEVELS     = 4;
  localparam int TASK_W     = 4;
  localparam int LEVEL_W    = 2;
  localparam int FIFO_DEPTH = LEVELS * TASKS;
  localparam int COUNT_W    = 5;

  // Event kinds
  localparam logic [2:0] EV_IDLE      = 3'd0;
  localparam logic [2:0] EV_STARTED   = 3'd1;
  localparam logic [2:0] EV_RESUMED   = 3'd2;
  localparam logic [2:0] EV_RUNNING   = 3'd3;
  localparam logic [2:0] EV_FINISHED  = 3'd4;
  localparam logic [2:0] EV_SUSPENDED = 3'd5;
  localparam logic [2:0] EV_TIMEOUT   = 3'd6;

  // Request types
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_ARRIVE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT    = 1'b0;
  localparam logic CFG_KILL_LEVEL = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET    = 16'd20;
  localparam logic [2:0]  KILL_LEVEL_RESET = 3'd3;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  task_id;
    logic [3:0]  task_priority;
    logic [15:0] burst_time;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  event_task;
    logic [1:0]  event_priority;
    logic [15:0] event_remaining;
    logic [15:0] event_time;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] lvl;
    logic [15:0]        rem;
    logic               begun;
    logic [15:0]        stamp;
  } task_rec_t;

endpackage

@@ src/fqts_ram.sv @@
// Generic single write, single read RAM with registered read data.
// No dependencies.
module fqts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/fqts_emit.sv @@
// Result staging for the scheduler: holds one event back so the final beat of
// a tick can carry last. Depends on fqts_pkg.
module fqts_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ev_valid,
  input  fqts_pkg::out_t ev_item,
  input  logic          flush,
  input  logic [15:0]   flush_time,
  output logic          out_valid,
  output fqts_pkg::out_t out_item
);

  logic           pend_v_r, pend_v_nxt;
  fqts_pkg::out_t pend_r, pend_nxt;
  logic           out_valid_r, out_valid_nxt;
  fqts_pkg::out_t out_r, out_nxt;

  // Release the held event when a newer one shows up or the tick ends
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (ev_valid) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_nxt.last  = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = ev_item;
    end else if (flush) begin
      out_valid_nxt = 1'b1;
      if (pend_v_r) begin
        out_nxt = pend_r;
      end else begin
        out_nxt                 = '0;
        out_nxt.event_kind      = fqts_pkg::EV_IDLE;
        out_nxt.event_time      = flush_time;
      end
      out_nxt.last = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    flush && !ev_valid |=> !pend_v_r) else $error("held event survived tick end");
  a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last |-> !pend_v_r) else $error("last beat with event held");
  a_ev_no_flush: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid |=> !(out_valid_r && out_r.last)) else $error("last set on a non-final beat");

endmodule

@@ src/feedback_queue_task_scheduler.sv @@
// Multilevel feedback queue scheduler top level: sequencer, task and queue RAMs.
// Depends on fqts_pkg, fqts_ram and fqts_emit.
//
// Usage: drive in_item and raise start while busy is low. An arrival beat is
// taken in the idle state and gives no result; busy stays low. A tick beat raises
// busy and walks the scheduler: pick, run one unit, finish or demote, then
// check all 16 task slots for timeouts. Each result appears on out_item for
// one cycle with out_valid high; the final beat of a tick has last set, and a
// tick with no event gives one idle beat. The receiver cannot hold results off.
// Sequence: a tick picks, runs and settles the holder, then walks the task
// slots for timeouts, reading only slots that have arrived, and closes; the
// last beat, registered in fqts_emit, appears as busy falls. Each removal
// walks its level queue entry by entry (read, then shift), and a demoted task
// is then requeued at the tail. The single read port of the queue RAM sets
// the removal cost.
// Configuration: cfg_we writes timeout_ticks (index 0) or kill_level_below
// (index 1) from cfg_data; write only while busy is low.
// Reset: synchronous rst_n clears time, counts, arrival marks and holder; the
// RAMs need no clearing since entries are only read after being written.
module feedback_queue_task_scheduler (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  fqts_pkg::in_t  in_item,
  output logic           out_valid,
  output fqts_pkg::out_t out_item,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SEL   = 4'd1;
  localparam logic [3:0] S_HCHK  = 4'd2;
  localparam logic [3:0] S_HFIFO = 4'd3;
  localparam logic [3:0] S_RUN   = 4'd4;
  localparam logic [3:0] S_POST  = 4'd5;
  localparam logic [3:0] S_PUSH  = 4'd6;
  localparam logic [3:0] S_TORD  = 4'd7;
  localparam logic [3:0] S_TOCHK = 4'd8;
  localparam logic [3:0] S_TONXT = 4'd9;
  localparam logic [3:0] S_RMRD  = 4'd10;
  localparam logic [3:0] S_RMCHK = 4'd11;
  localparam logic [3:0] S_END   = 4'd12;

  localparam int FA_W = $clog2(fqts_pkg::FIFO_DEPTH);
  localparam int TR_W = $bits(fqts_pkg::task_rec_t);

  logic [3:0]  state_r, state_nxt;
  logic [15:0] time_r, time_nxt;
  logic [15:0] to_r, to_nxt;
  logic [2:0]  klb_r, klb_nxt;
  logic [fqts_pkg::TASKS-1:0] arrived_r, arrived_nxt;
  logic [fqts_pkg::COUNT_W-1:0] count_r [fqts_pkg::LEVELS];
  logic [fqts_pkg::COUNT_W-1:0] count_nxt [fqts_pkg::LEVELS];
  logic [3:0]  holder_r, holder_nxt;
  logic        holder_v_r, holder_v_nxt;
  logic [3:0]  prior_r, prior_nxt;
  logic        prior_v_r, prior_v_nxt;
  fqts_pkg::task_rec_t cur_r, cur_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [1:0]  rm_lvl_r, rm_lvl_nxt;
  logic [3:0]  rm_task_r, rm_task_nxt;
  logic [3:0]  rm_j_r, rm_j_nxt;
  logic        rm_found_r, rm_found_nxt;
  logic [3:0]  rm_ret_r, rm_ret_nxt;
  logic [1:0]  push_lvl_r, push_lvl_nxt;

  // RAM ports
  logic                t_we, t_re;
  logic [3:0]          t_waddr, t_raddr;
  fqts_pkg::task_rec_t t_wdata, t_q;
  logic [TR_W-1:0]     t_q_raw;
  logic                f_we, f_re;
  logic [FA_W-1:0]     f_waddr, f_raddr;
  logic [3:0]          f_wdata, f_q;

  // Event staging
  logic           ev_v, flush;
  fqts_pkg::out_t ev;

  logic        accept;
  logic [1:0]  arr_lvl;
  logic        any_level;
  logic [1:0]  top_level;
  logic [15:0] passed;
  logic        kill;
  logic [1:0]  dem_lvl;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign t_q    = fqts_pkg::task_rec_t'(t_q_raw);

  // Clamp arrival level to the lowest level
  assign arr_lvl = (in_item.task_priority[3:2] != 2'd0) ?
                   2'(fqts_pkg::LEVELS - 1) : in_item.task_priority[1:0];

  // Highest non-empty level
  always_comb begin
    any_level = 1'b0;
    top_level = '0;
    for (int p = fqts_pkg::LEVELS - 1; p >= 0; p--) begin
      if (count_r[p] != '0) begin
        any_level = 1'b1;
        top_level = 2'(p);
      end
    end
  end

  assign passed  = time_r - t_q.stamp;
  assign kill    = (t_q.rem != 16'd0) && (passed >= to_r) &&
                   !(t_q.begun && ({1'b0, t_q.lvl} >= klb_r));
  assign dem_lvl = (cur_r.lvl == 2'(fqts_pkg::LEVELS - 1)) ? cur_r.lvl : cur_r.lvl + 2'd1;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    time_nxt     = time_r;
    to_nxt       = to_r;
    klb_nxt      = klb_r;
    arrived_nxt  = arrived_r;
    count_nxt    = count_r;
    holder_nxt   = holder_r;
    holder_v_nxt = holder_v_r;
    prior_nxt    = prior_r;
    prior_v_nxt  = prior_v_r;
    cur_nxt      = cur_r;
    k_nxt        = k_r;
    rm_lvl_nxt   = rm_lvl_r;
    rm_task_nxt  = rm_task_r;
    rm_j_nxt     = rm_j_r;
    rm_found_nxt = rm_found_r;
    rm_ret_nxt   = rm_ret_r;
    push_lvl_nxt = push_lvl_r;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_re = 1'b0; t_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_re = 1'b0; f_raddr = '0;
    ev_v = 1'b0; ev = '0; flush = 1'b0;

    // Configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        fqts_pkg::CFG_TIMEOUT:    to_nxt  = cfg_data;
        fqts_pkg::CFG_KILL_LEVEL: klb_nxt = cfg_data[2:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.req_type == fqts_pkg::REQ_ARRIVE) begin
            // Record the task and append it to its level queue
            if (!arrived_r[in_item.task_id]) begin
              arrived_nxt[in_item.task_id] = 1'b1;
              t_we    = 1'b1;
              t_waddr = in_item.task_id;
              t_wdata = '{lvl: arr_lvl, rem: in_item.burst_time, begun: 1'b0,
                          stamp: time_r};
              if (count_r[arr_lvl] < fqts_pkg::COUNT_W'(fqts_pkg::TASKS)) begin
                f_we    = 1'b1;
                f_waddr = {arr_lvl, count_r[arr_lvl][3:0]};
                f_wdata = in_item.task_id;
                count_nxt[arr_lvl] = count_r[arr_lvl] + 1'b1;
              end
            end
          end else begin
            state_nxt = S_SEL;
          end
        end
      end
      S_SEL: begin
        if (holder_v_r) begin
          t_re      = 1'b1;
          t_raddr   = holder_r;
          state_nxt = S_HCHK;
        end else if (any_level) begin
          f_re      = 1'b1;
          f_raddr   = {top_level, 4'd0};
          state_nxt = S_HFIFO;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_HCHK: begin
        // Keep a level-0 holder with work left, else pick again
        if (t_q.lvl == 2'd0 && t_q.rem != 16'd0) begin
          state_nxt = S_RUN;
        end else begin
          holder_v_nxt = 1'b0;
          state_nxt    = S_SEL;
        end
      end
      S_HFIFO: begin
        holder_nxt   = f_q;
        holder_v_nxt = 1'b1;
        t_re         = 1'b1;
        t_raddr      = f_q;
        state_nxt    = S_RUN;
      end
      S_RUN: begin
        cur_nxt = t_q;
        if (holder_v_r && t_q.rem != 16'd0) begin
          ev_v = 1'b1;
          if (!t_q.begun) begin
            ev.event_kind = fqts_pkg::EV_STARTED;
          end else if (!prior_v_r || prior_r != holder_r) begin
            ev.event_kind = fqts_pkg::EV_RESUMED;
          end else begin
            ev.event_kind = fqts_pkg::EV_RUNNING;
          end
          ev.event_task      = holder_r;
          ev.event_priority  = t_q.lvl;
          ev.event_remaining = t_q.rem;
          ev.event_time      = time_r;
          cur_nxt.rem   = t_q.rem - 16'd1;
          cur_nxt.begun = 1'b1;
          t_we    = 1'b1;
          t_waddr = holder_r;
          t_wdata = cur_nxt;
          prior_nxt   = holder_r;
          prior_v_nxt = 1'b1;
        end
        time_nxt  = time_r + 16'd1;
        k_nxt     = '0;
        state_nxt = holder_v_r ? S_POST : S_TORD;
      end
      S_POST: begin
        rm_lvl_nxt   = cur_r.lvl;
        rm_task_nxt  = holder_r;
        rm_j_nxt     = '0;
        rm_found_nxt = 1'b0;
        if (cur_r.rem == 16'd0) begin
          // Finished: drop from its queue
          ev_v = 1'b1;
          ev.event_kind     = fqts_pkg::EV_FINISHED;
          ev.event_task     = holder_r;
          ev.event_priority = cur_r.lvl;
          ev.event_time     = time_r;
          holder_v_nxt = 1'b0;
          prior_v_nxt  = 1'b0;
          rm_ret_nxt   = S_TORD;
          state_nxt    = S_RMRD;
        end else if (cur_r.lvl != 2'd0) begin
          // Demote and requeue at the tail
          ev_v = 1'b1;
          ev.event_kind      = fqts_pkg::EV_SUSPENDED;
          ev.event_task      = holder_r;
          ev.event_priority  = dem_lvl;
          ev.event_remaining = cur_r.rem;
          ev.event_time      = time_r;
          t_we    = 1'b1;
          t_waddr = holder_r;
          t_wdata = '{lvl: dem_lvl, rem: cur_r.rem, begun: cur_r.begun,
                      stamp: cur_r.stamp};
          holder_v_nxt = 1'b0;
          push_lvl_nxt = dem_lvl;
          rm_ret_nxt   = S_PUSH;
          state_nxt    = S_RMRD;
        end else begin
          state_nxt = S_TORD;
        end
      end
      S_PUSH: begin
        if (count_r[push_lvl_r] < fqts_pkg::COUNT_W'(fqts_pkg::TASKS)) begin
          f_we    = 1'b1;
          f_waddr = {push_lvl_r, count_r[push_lvl_r][3:0]};
          f_wdata = holder_r;
          count_nxt[push_lvl_r] = count_r[push_lvl_r] + 1'b1;
        end
        state_nxt = S_TORD;
      end
      S_TORD: begin
        if (arrived_r[k_r]) begin
          t_re      = 1'b1;
          t_raddr   = k_r;
          state_nxt = S_TOCHK;
        end else begin
          state_nxt = S_TONXT;
        end
      end
      S_TOCHK: begin
        state_nxt = S_TONXT;
        if (kill) begin
          ev_v = 1'b1;
          ev.event_kind      = fqts_pkg::EV_TIMEOUT;
          ev.event_task      = k_r;
          ev.event_priority  = t_q.lvl;
          ev.event_remaining = t_q.rem;
          ev.event_time      = time_r;
          t_we    = 1'b1;
          t_waddr = k_r;
          t_wdata = '{lvl: t_q.lvl, rem: 16'd0, begun: t_q.begun, stamp: t_q.stamp};
          if (holder_v_r && holder_r == k_r) begin
            holder_v_nxt = 1'b0;
          end
          rm_lvl_nxt   = t_q.lvl;
          rm_task_nxt  = k_r;
          rm_j_nxt     = '0;
          rm_found_nxt = 1'b0;
          rm_ret_nxt   = S_TONXT;
          state_nxt    = S_RMRD;
        end
      end
      S_TONXT: begin
        k_nxt     = k_r + 4'd1;
        state_nxt = (k_r == 4'(fqts_pkg::TASKS - 1)) ? S_END : S_TORD;
      end
      S_RMRD: begin
        if ({1'b0, rm_j_r} >= count_r[rm_lvl_r]) begin
          state_nxt = rm_ret_r;
        end else begin
          f_re      = 1'b1;
          f_raddr   = {rm_lvl_r, rm_j_r};
          state_nxt = S_RMCHK;
        end
      end
      S_RMCHK: begin
        // Shift entries behind the match down by one
        if (rm_found_r) begin
          f_we    = 1'b1;
          f_waddr = {rm_lvl_r, rm_j_r - 4'd1};
          f_wdata = f_q;
        end
        rm_found_nxt = rm_found_r || (f_q == rm_task_r);
        if (({1'b0, rm_j_r} + 5'd1) < count_r[rm_lvl_r]) begin
          rm_j_nxt  = rm_j_r + 4'd1;
          state_nxt = S_RMRD;
        end else begin
          if (rm_found_nxt) begin
            count_nxt[rm_lvl_r] = count_r[rm_lvl_r] - 1'b1;
          end
          state_nxt = rm_ret_r;
        end
      end
      S_END: begin
        flush     = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      time_r     <= '0;
      to_r       <= fqts_pkg::TIMEOUT_RESET;
      klb_r      <= fqts_pkg::KILL_LEVEL_RESET;
      arrived_r  <= '0;
      for (int p = 0; p < fqts_pkg::LEVELS; p++) begin
        count_r[p] <= '0;
      end
      holder_v_r <= 1'b0;
      prior_v_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      time_r     <= time_nxt;
      to_r       <= to_nxt;
      klb_r      <= klb_nxt;
      arrived_r  <= arrived_nxt;
      count_r    <= count_nxt;
      holder_v_r <= holder_v_nxt;
      prior_v_r  <= prior_v_nxt;
    end
    holder_r   <= holder_nxt;
    prior_r    <= prior_nxt;
    cur_r      <= cur_nxt;
    k_r        <= k_nxt;
    rm_lvl_r   <= rm_lvl_nxt;
    rm_task_r  <= rm_task_nxt;
    rm_j_r     <= rm_j_nxt;
    rm_found_r <= rm_found_nxt;
    rm_ret_r   <= rm_ret_nxt;
    push_lvl_r <= push_lvl_nxt;
  end

  fqts_ram #(.WIDTH(TR_W), .DEPTH(fqts_pkg::TASKS)) u_task_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (TR_W'(t_wdata)),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_q_raw)
  );

  fqts_ram #(.WIDTH(fqts_pkg::TASK_W), .DEPTH(fqts_pkg::FIFO_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_q)
  );

  fqts_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev_valid   (ev_v),
    .ev_item    (ev),
    .flush      (flush),
    .flush_time (time_r),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.req_type == fqts_pkg::REQ_TICK |=> busy)
    else $error("tick did not start");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !busy) else $error("last beat while still busy");
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[0] <= 5'd16 && count_r[1] <= 5'd16 &&
    count_r[2] <= 5'd16 && count_r[3] <= 5'd16) else $error("queue overfilled");
  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !ev_v) else $error("event outside a tick");

endmodule
